// ===== rtl/source_text_tokenizer_defines.svh =====
// Assertion macros used by the tokenizer top level.
`ifndef SOURCE_TEXT_TOKENIZER_DEFINES_SVH
`define SOURCE_TEXT_TOKENIZER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define STT_ASSERT_IMPL(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("tokenizer assertion failed");

// Next-cycle implication, disabled while reset is low.
`define STT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tokenizer assertion failed");

`endif

// ===== rtl/stt_pkg.sv =====
// Types, constants and decode functions for the source text tokenizer.
package stt_pkg;

  localparam int NAME_LIMIT = 31;
  localparam int TEXT_LIMIT = 100;
  localparam int WIN        = 6;
  localparam int WIN_AW     = $clog2(WIN);
  localparam int KW_NUM     = 6;
  localparam int MAX_RES    = 3;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // token kinds
  localparam logic [4:0] K_UNKNOWN = 5'd0;
  localparam logic [4:0] K_NAME    = 5'd1;
  localparam logic [4:0] K_NUMBER  = 5'd2;
  localparam logic [4:0] K_STRING  = 5'd3;
  localparam logic [4:0] K_ASSIGN  = 5'd4;
  localparam logic [4:0] K_EQUAL   = 5'd5;
  localparam logic [4:0] K_COLON   = 5'd6;
  localparam logic [4:0] K_SEMI    = 5'd7;
  localparam logic [4:0] K_COMMA   = 5'd8;
  localparam logic [4:0] K_DOT     = 5'd9;
  localparam logic [4:0] K_CLASS   = 5'd10;
  localparam logic [4:0] K_FUNC    = 5'd11;
  localparam logic [4:0] K_IF      = 5'd12;
  localparam logic [4:0] K_ELIF    = 5'd13;
  localparam logic [4:0] K_ELSE    = 5'd14;
  localparam logic [4:0] K_LPAREN  = 5'd15;
  localparam logic [4:0] K_RPAREN  = 5'd16;
  localparam logic [4:0] K_LSQUARE = 5'd17;
  localparam logic [4:0] K_RSQUARE = 5'd18;
  localparam logic [4:0] K_LBRACE  = 5'd19;
  localparam logic [4:0] K_RBRACE  = 5'd20;
  localparam logic [4:0] K_ADD     = 5'd21;
  localparam logic [4:0] K_SUB     = 5'd22;
  localparam logic [4:0] K_MULT    = 5'd23;
  localparam logic [4:0] K_DIVI    = 5'd24;
  localparam logic [4:0] K_MOD     = 5'd25;
  localparam logic [4:0] K_LESS    = 5'd26;
  localparam logic [4:0] K_GREAT   = 5'd27;
  localparam logic [4:0] K_PRINT   = 5'd28;
  localparam logic [4:0] K_EOI     = 5'd29;
  localparam logic [4:0] K_TOOLONG = 5'd30;

  localparam logic RT_TEXT = 1'b0;
  localparam logic RT_END  = 1'b1;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_NAME = 3'd1,
    MODE_NUM  = 3'd2,
    MODE_EQ   = 3'd3,
    MODE_SQ   = 3'd4,
    MODE_DQ   = 3'd5,
    MODE_HALT = 3'd6,
    MODE_END  = 3'd7
  } scan_mode_t;

  typedef logic [WIN-1:0][7:0] kw_win_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic       result_type;
    logic [7:0] text_byte;
    logic [4:0] token_kind;
    logic [6:0] token_length;
    logic       last_of_run;
  } out_item_t;

  // all results one request causes; cnt is 1..MAX_RES
  typedef struct packed {
    logic [1:0]                  cnt;
    out_item_t [MAX_RES-1:0]     res;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // keyword text, first character in element 0, zero padded
  localparam kw_win_t KW_TEXT [KW_NUM] = '{
    {8'h00, "s", "s", "a", "l", "c"},
    {8'h00, 8'h00, "c", "n", "u", "f"},
    {8'h00, 8'h00, 8'h00, 8'h00, "f", "i"},
    {8'h00, 8'h00, "f", "i", "l", "e"},
    {8'h00, 8'h00, "e", "s", "l", "e"},
    {8'h00, "t", "n", "i", "r", "p"}
  };
  localparam logic [6:0] KW_LEN [KW_NUM] = '{7'd5, 7'd4, 7'd2, 7'd4, 7'd4, 7'd5};
  localparam logic [4:0] KW_KIND [KW_NUM] = '{K_CLASS, K_FUNC, K_IF, K_ELIF, K_ELSE, K_PRINT};

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic [4:0] single_kind(input logic [7:0] c);
    logic [4:0] k;
    unique case (c)
      ":":     k = K_COLON;
      ";":     k = K_SEMI;
      ",":     k = K_COMMA;
      ".":     k = K_DOT;
      "(":     k = K_LPAREN;
      ")":     k = K_RPAREN;
      "[":     k = K_LSQUARE;
      "]":     k = K_RSQUARE;
      "{":     k = K_LBRACE;
      "}":     k = K_RBRACE;
      "+":     k = K_ADD;
      "-":     k = K_SUB;
      "*":     k = K_MULT;
      "/":     k = K_DIVI;
      "%":     k = K_MOD;
      "<":     k = K_LESS;
      ">":     k = K_GREAT;
      default: k = K_UNKNOWN;
    endcase
    return k;
  endfunction

  // window bytes past the count are always zero, so a whole-window
  // compare against the padded keyword plus a length check is exact
  function automatic logic [4:0] name_kind(input kw_win_t win, input logic [6:0] cnt);
    logic [4:0] k;
    k = K_NAME;
    for (int i = KW_NUM - 1; i >= 0; i--) begin
      if (cnt == KW_LEN[i] && win == KW_TEXT[i]) k = KW_KIND[i];
    end
    return k;
  endfunction

  function automatic logic [4:0] open_kind(input scan_mode_t mode, input kw_win_t win,
                                           input logic [6:0] cnt);
    logic [4:0] k;
    unique case (mode)
      MODE_NUM:  k = K_NUMBER;
      MODE_EQ:   k = (cnt == 7'd1) ? K_ASSIGN : ((cnt == 7'd2) ? K_EQUAL : K_UNKNOWN);
      MODE_NAME: k = name_kind(win, cnt);
      default:   k = K_STRING;
    endcase
    return k;
  endfunction

  function automatic out_item_t mk_text(input logic [7:0] c);
    out_item_t r;
    r = '0;
    r.result_type = RT_TEXT;
    r.text_byte   = c;
    return r;
  endfunction

  function automatic out_item_t mk_end(input logic [4:0] kind, input logic [6:0] len);
    out_item_t r;
    r = '0;
    r.result_type  = RT_END;
    r.token_kind   = kind;
    r.token_length = len;
    return r;
  endfunction

endpackage

// ===== rtl/stt_front.sv =====
// Front end: accepts characters, runs the scanner state and builds result bundles.
module stt_front import stt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  input  fifo_stat_t fstat,
  output logic       push,
  output bundle_t    push_data
);

  scan_mode_t mode_r, mode_nxt;
  kw_win_t    win_r, win_nxt;
  logic [6:0] cnt_r, cnt_nxt;

  logic       fire;
  logic [7:0] c;
  logic       eoi;

  out_item_t [MAX_RES-1:0] res_v;
  logic [1:0] n_v;
  logic       start_v;
  logic       keep_v;
  logic [6:0] lim_v;
  logic       more_v;

  assign in_stall = fstat.full;
  assign fire     = in_valid && !in_stall;
  assign c        = in_data.char_code;
  assign eoi      = in_data.end_of_input;

  always_comb begin
    mode_nxt = mode_r;
    win_nxt  = win_r;
    cnt_nxt  = cnt_r;
    res_v    = '0;
    n_v      = 2'd0;
    start_v  = 1'b0;
    keep_v   = 1'b0;
    lim_v    = 7'(TEXT_LIMIT);
    more_v   = 1'b0;

    unique case (mode_r) inside
      MODE_HALT: ;
      MODE_END: begin
        if (eoi) begin
          res_v[n_v] = mk_end(K_EOI, 7'd0);
          n_v = n_v + 2'd1;
        end
      end
      MODE_NAME, MODE_NUM, MODE_EQ: begin
        if (mode_r == MODE_NAME) more_v = is_letter(c) || is_digit(c);
        else if (mode_r == MODE_NUM) more_v = is_digit(c) || c == ".";
        else more_v = c == "=";
        if (eoi) begin
          res_v[n_v] = mk_end(open_kind(mode_r, win_r, cnt_r), cnt_r);
          n_v = n_v + 2'd1;
          res_v[n_v] = mk_end(K_EOI, 7'd0);
          n_v = n_v + 2'd1;
          win_nxt  = '0;
          cnt_nxt  = '0;
          mode_nxt = MODE_END;
        end else if (more_v) begin
          keep_v = 1'b1;
          lim_v  = (mode_r == MODE_NAME) ? 7'(NAME_LIMIT) : 7'(TEXT_LIMIT);
        end else begin
          res_v[n_v] = mk_end(open_kind(mode_r, win_r, cnt_r), cnt_r);
          n_v = n_v + 2'd1;
          start_v = 1'b1;
        end
      end
      MODE_SQ, MODE_DQ: begin
        if (eoi) begin
          res_v[n_v] = mk_end(K_STRING, cnt_r);
          n_v = n_v + 2'd1;
          res_v[n_v] = mk_end(K_EOI, 7'd0);
          n_v = n_v + 2'd1;
          win_nxt  = '0;
          cnt_nxt  = '0;
          mode_nxt = MODE_END;
        end else if (c == 8'h0a || c == ((mode_r == MODE_SQ) ? 8'h27 : 8'h22)) begin
          res_v[n_v] = mk_end(K_STRING, cnt_r);
          n_v = n_v + 2'd1;
          win_nxt  = '0;
          cnt_nxt  = '0;
          mode_nxt = MODE_IDLE;
        end else if (cnt_r >= 7'(TEXT_LIMIT)) begin
          res_v[n_v] = mk_end(K_TOOLONG, cnt_r);
          n_v = n_v + 2'd1;
          mode_nxt = MODE_HALT;
        end else begin
          keep_v = 1'b1;
        end
      end
      default: begin
        if (eoi) begin
          res_v[n_v] = mk_end(K_EOI, 7'd0);
          n_v = n_v + 2'd1;
          win_nxt  = '0;
          cnt_nxt  = '0;
          mode_nxt = MODE_END;
        end else begin
          start_v = 1'b1;
        end
      end
    endcase

    // first character of a new token
    if (start_v) begin
      win_nxt = '0;
      cnt_nxt = '0;
      if (is_space(c)) begin
        mode_nxt = MODE_IDLE;
      end else if (is_letter(c)) begin
        mode_nxt = MODE_NAME;
        keep_v   = 1'b1;
        lim_v    = 7'(NAME_LIMIT);
      end else if (is_digit(c)) begin
        mode_nxt = MODE_NUM;
        keep_v   = 1'b1;
      end else if (c == "=") begin
        mode_nxt = MODE_EQ;
        keep_v   = 1'b1;
      end else if (c == 8'h27) begin
        mode_nxt = MODE_SQ;
      end else if (c == 8'h22) begin
        mode_nxt = MODE_DQ;
      end else begin
        mode_nxt = MODE_IDLE;
        res_v[n_v] = mk_text(c);
        n_v = n_v + 2'd1;
        res_v[n_v] = mk_end(single_kind(c), 7'd1);
        n_v = n_v + 2'd1;
      end
    end

    // append to token text, dropped once the limit is reached
    if (keep_v && cnt_nxt < lim_v) begin
      if (cnt_nxt < 7'(WIN)) win_nxt[cnt_nxt[WIN_AW-1:0]] = c;
      cnt_nxt = cnt_nxt + 7'd1;
      res_v[n_v] = mk_text(c);
      n_v = n_v + 2'd1;
    end

    if (n_v != 2'd0) res_v[n_v - 2'd1].last_of_run = 1'b1;
  end

  assign push          = fire && (n_v != 2'd0);
  assign push_data.cnt = n_v;
  assign push_data.res = res_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      win_r  <= '0;
      cnt_r  <= '0;
    end else if (fire) begin
      mode_r <= mode_nxt;
      win_r  <= win_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/stt_fifo.sv =====
// Short bundle queue between the front end and the result sequencer.
module stt_fifo import stt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  bundle_t    push_data,
  input  logic       pop,
  output bundle_t    head,
  output fifo_stat_t fstat
);

  bundle_t              mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_r, rd_r;
  logic [FIFO_AW:0]     fill_r;

  assign head        = mem_r[rd_r];
  assign fstat.full  = fill_r == (FIFO_AW + 1)'(FIFO_DEPTH);
  assign fstat.empty = fill_r == '0;

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r   <= '0;
      rd_r   <= '0;
      fill_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + FIFO_AW'(1);
      if (pop)  rd_r <= rd_r + FIFO_AW'(1);
      if (push && !pop)      fill_r <= fill_r + (FIFO_AW + 1)'(1);
      else if (pop && !push) fill_r <= fill_r - (FIFO_AW + 1)'(1);
    end
  end

endmodule

// ===== rtl/stt_back.sv =====
// Back end: holds one bundle and hands its results out one per cycle while out_stall is low.
module stt_back import stt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  bundle_t    head,
  input  fifo_stat_t fstat,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data
);

  bundle_t    bnd_r;
  logic [1:0] idx_r;
  logic       have_r;
  logic       out_fire;
  logic       at_last;

  assign out_valid = have_r;
  assign out_data  = bnd_r.res[idx_r];
  assign out_fire  = have_r && !out_stall;
  assign at_last   = idx_r == (bnd_r.cnt - 2'd1);
  assign pop       = (!have_r || (out_fire && at_last)) && !fstat.empty;

  always_ff @(posedge clk) begin
    if (pop) bnd_r <= head;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
      idx_r  <= '0;
    end else if (pop) begin
      have_r <= 1'b1;
      idx_r  <= '0;
    end else if (out_fire) begin
      if (at_last) have_r <= 1'b0;
      else idx_r <= idx_r + 2'd1;
    end
  end

endmodule

// ===== rtl/source_text_tokenizer.sv =====
// A character's first result passes the bundle queue, then the back-end bundle register.
// Throughput: one character per cycle unless the queue is full; one result leaves
//   per cycle from the single output port unless stalled, up to three per character.
// The four-deep bundle queue absorbs bursts and output stalls between the two ends.
// Reset: rst_n synchronous, active low; clears scanner mode, text count,
//   keyword window, queue pointers and the output valid.
`include "source_text_tokenizer_defines.svh"

module source_text_tokenizer import stt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  // front to queue
  logic       push;
  bundle_t    push_data;
  // queue to back
  bundle_t    head;
  logic       pop;
  fifo_stat_t fstat;

  // Front end: one character per request; the full scanner step is combinational.
  // Keyword lookup is a parallel compare against the constant table.
  stt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .fstat     (fstat),
    .push      (push),
    .push_data (push_data)
  );

  // Queue: only characters that produce results are written.
  stt_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .fstat     (fstat)
  );

  // Back end: registered output, steps through a bundle under out_stall.
  stt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .fstat     (fstat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // checks
  `STT_ASSERT_IMPL(a_no_overflow, clk, rst_n, push, !fstat.full)
  `STT_ASSERT_IMPL(a_end_no_byte, clk, rst_n, out_valid && out_data.result_type, out_data.text_byte == 8'd0)
  `STT_ASSERT_IMPL(a_text_no_kind, clk, rst_n, out_valid && !out_data.result_type, out_data.token_kind == K_UNKNOWN && out_data.token_length == 7'd0)
  `STT_ASSERT_NEXT(a_pop_shows, clk, rst_n, pop, out_valid)

endmodule
